// ----- design/nau_pkg.sv -----
package nau_pkg;

	// word format
	localparam int WORD_W        = 24;
	localparam int FRAC_BITS     = 16;
	localparam int TABLE_ENTRIES = 256;
	localparam int SCALE_DIV     = 100;
	localparam int HALF_DIV      = SCALE_DIV / 2;

	// sigmoid table
	localparam int ROM_FRAC = 30;
	localparam int ROM_W    = ROM_FRAC + 1;
	localparam int IDX_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int POS_SH   = FRAC_BITS + 4;
	localparam int ARG_W    = WORD_W + 1;
	localparam int POS_W    = ARG_W + IDX_W;
	localparam int RND_SH   = ROM_FRAC - FRAC_BITS;

	// datapath widths
	localparam int OPB_W   = WORD_W + 1;
	localparam int PROD_W  = WORD_W + OPB_W;
	localparam int DER_W   = PROD_W + 1;
	localparam int NUM_W   = (2 * WORD_W - FRAC_BITS > WORD_W + 1) ?
		(2 * WORD_W - FRAC_BITS) : (WORD_W + 1);
	localparam int Q_W     = NUM_W - 6;
	localparam int RECIP_W = NUM_W - 6;
	localparam longint unsigned RECIP = (64'd1 << NUM_W) / SCALE_DIV;

	// fixed-point constants
	localparam longint ONE_Q       = longint'(1) << FRAC_BITS;
	localparam longint ONE_SQ      = longint'(1) << (2 * FRAC_BITS);
	localparam longint ROM_ONE     = longint'(1) << ROM_FRAC;
	localparam longint RND_HALF    = longint'(1) << (RND_SH - 1);
	localparam longint RND_HALF100 = longint'(HALF_DIV) << RND_SH;
	localparam longint DER_HALF    = longint'(1) << (FRAC_BITS - 1);
	localparam longint DER_HALF100 = longint'(HALF_DIV) << FRAC_BITS;
	localparam longint RELU_DER_LOW = (ONE_Q + HALF_DIV) / SCALE_DIV;
	localparam longint SAT_POS     = (longint'(1) << (WORD_W - 1)) - 1;
	localparam longint SAT_NEG_MAG = longint'(1) << (WORD_W - 1);

	// register map
	localparam int ADDR_W    = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_MODE = '0;

	typedef logic [1:0] mode_t;
	localparam mode_t MODE_SIGMOID = 2'd0;
	localparam mode_t MODE_RELU    = 2'd1;
	localparam mode_t MODE_TANH    = 2'd2;

	localparam logic FUNC_FWD = 1'b0;
	localparam logic FUNC_DER = 1'b1;

	typedef struct packed {
		logic                     func;
		logic signed [WORD_W-1:0] value;
		logic                     is_last;
	} nau_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] result;
		logic                     last_out;
	} nau_rsp_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [POS_SH-1:0] frac;
		logic              oor;
	} nau_lut_t;

	typedef struct packed {
		logic                     func;
		mode_t                    mode;
		logic signed [WORD_W-1:0] x;
		logic                     last;
	} nau_ctl_t;

	typedef struct packed {
		logic  func;
		mode_t mode;
		logic  div;
		logic  neg;
		logic  base;
		logic  last;
	} nau_fin_t;

	// shift-and-subtract long division for table generation
	function automatic longint unsigned udiv64(input longint unsigned num,
		input longint unsigned den);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], num[i]};
			q = {q[62:0], 1'b0};
			if (r >= den) begin
				r    = r - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// sigmoid sample k, 30 fraction bits; evaluated at elaboration only
	function automatic logic [ROM_W-1:0] rom_entry(input int k);
		longint          acc;
		longint unsigned term;
		longint unsigned e;
		longint unsigned p;
		longint unsigned d;
		longint unsigned q;
		acc  = longint'(1) << 32;
		term = 64'd1 << 32;
		for (int n = 1; n <= 24; n++) begin
			term = udiv64(term * 64'd16, 64'(TABLE_ENTRIES) * 64'(n));
			if (n % 2 == 1) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		e = longint'(acc);
		p = 64'd1 << 32;
		for (int j = 0; j < k; j++) begin
			p = (p * e + (64'd1 << 31)) >> 32;
		end
		d = (64'd1 << 32) + p;
		q = udiv64((64'd1 << 62) + (d >> 1), d);
		return q[ROM_W-1:0];
	endfunction

endpackage

// ----- design/neural_activation_unit.sv -----
// Activation unit: sigmoid, clipped leaky ReLU and leaky tanh on signed
// Q8.16 operands, forward value or derivative from an activated value.
//
// Request channel: req is taken at a rising edge with start high and busy
// low. busy is always low, so a new request can enter every cycle.
// Result channel: done is high for one cycle with rsp; the receiver must
// take it then, there is no back pressure.
// Throughput is one request per cycle. A request passes through eight
// register stages: operand prep, table read, interpolation multiply,
// table/derivative combine, rounding, two stages of constant divide by
// 100, and saturation. Configuration: APB port, register 0 (byte address
// 0) holds mode; the user must write it only while no request is in
// flight, the block does not enforce this. pready is always high.
// Reset clears all stage valid bits and sets mode to clipped leaky ReLU;
// the sigmoid table is constant logic and needs no fill.
module neural_activation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  nau_pkg::nau_req_t             req,
	output logic                          done,
	output nau_pkg::nau_rsp_t             rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nau_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int XW = nau_pkg::WORD_W;
	localparam int NW = nau_pkg::NUM_W;
	localparam int WW = nau_pkg::DER_W + 1;

	localparam logic signed [WW-1:0] K_ONE     = WW'(nau_pkg::ONE_Q);
	localparam logic signed [WW-1:0] K_50      = WW'(nau_pkg::HALF_DIV);
	localparam logic signed [WW-1:0] K_ROM_ONE = WW'(nau_pkg::ROM_ONE);
	localparam logic signed [WW-1:0] K_HF      = WW'(nau_pkg::RND_HALF);
	localparam logic signed [WW-1:0] K_H50F    = WW'(nau_pkg::RND_HALF100);
	localparam logic signed [WW-1:0] K_HD      = WW'(nau_pkg::DER_HALF);
	localparam logic signed [WW-1:0] K_H50D    = WW'(nau_pkg::DER_HALF100);
	localparam logic [NW:0]          K_SAT_POS = (NW+1)'(nau_pkg::SAT_POS);
	localparam logic [NW:0]          K_SAT_NEG = (NW+1)'(nau_pkg::SAT_NEG_MAG);

	nau_pkg::mode_t mode;
	logic           acc;

	nau_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.mode    (mode)
	);

	assign busy = 1'b0;
	assign acc  = start && !busy;

	// ---------------- stage 1: operand prep ----------------
	logic                                neg_c;
	logic [XW-1:0]                       mag_c;
	logic [nau_pkg::ARG_W-1:0]           arg_c;
	logic [nau_pkg::POS_W-1:0]           pos_c;
	logic [nau_pkg::POS_W-nau_pkg::POS_SH-1:0] ipart_c;
	logic                                oor_c;
	logic signed [nau_pkg::OPB_W-1:0]    opb_c;

	assign neg_c   = req.value[XW-1];
	assign mag_c   = neg_c ? (~req.value + 1'b1) : req.value;
	assign arg_c   = (mode == nau_pkg::MODE_TANH) ? {mag_c, 1'b0} : {1'b0, mag_c};
	assign pos_c   = arg_c * nau_pkg::POS_W'(nau_pkg::TABLE_ENTRIES);
	assign ipart_c = pos_c[nau_pkg::POS_W-1:nau_pkg::POS_SH];
	assign oor_c   = ipart_c >= (nau_pkg::POS_W-nau_pkg::POS_SH)'(nau_pkg::TABLE_ENTRIES);
	assign opb_c   = (mode == nau_pkg::MODE_SIGMOID) ?
		(nau_pkg::OPB_W'(nau_pkg::ONE_Q) - nau_pkg::OPB_W'(req.value)) :
		nau_pkg::OPB_W'(req.value);

	logic                             vld_s1;
	nau_pkg::nau_ctl_t                ctl_s1;
	nau_pkg::nau_lut_t                lut_s1;
	logic signed [nau_pkg::OPB_W-1:0] opb_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			ctl_s1.func   <= req.func;
			ctl_s1.mode   <= mode;
			ctl_s1.x      <= req.value;
			ctl_s1.last   <= req.is_last;
			lut_s1.idx    <= oor_c ? '0 : ipart_c[nau_pkg::IDX_W-1:0];
			lut_s1.frac   <= pos_c[nau_pkg::POS_SH-1:0];
			lut_s1.oor    <= oor_c;
			opb_s1        <= opb_c;
		end
	end

	// ---------------- stages 2-4: table path and derivative product ----------------
	logic [nau_pkg::ROM_W-1:0] sig_s4;

	nau_sigmoid u_sig (
		.clk (clk),
		.lut (lut_s1),
		.sig (sig_s4)
	);

	logic signed [nau_pkg::PROD_W-1:0] prod_c;
	logic signed [nau_pkg::DER_W-1:0]  der_c;

	logic                              vld_s2, vld_s3, vld_s4;
	nau_pkg::nau_ctl_t                 ctl_s2, ctl_s3, ctl_s4;
	logic signed [nau_pkg::PROD_W-1:0] prod_s2, prod_s3;
	logic signed [nau_pkg::DER_W-1:0]  der_s4;

	assign prod_c = nau_pkg::PROD_W'(ctl_s1.x) * nau_pkg::PROD_W'(opb_s1);
	assign der_c  = (ctl_s3.mode == nau_pkg::MODE_TANH) ?
		(nau_pkg::DER_W'(nau_pkg::ONE_SQ) - nau_pkg::DER_W'(prod_s3)) :
		nau_pkg::DER_W'(prod_s3);

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		prod_s2 <= prod_c;
		ctl_s3  <= ctl_s2;
		prod_s3 <= prod_s2;
		ctl_s4  <= ctl_s3;
		der_s4  <= der_c;
	end

	// ---------------- stage 5: rounding and divide setup ----------------
	logic signed [WW-1:0] xw, vw, dw, hw, w;
	logic                 xneg;
	logic [NW-1:0]        num_c;
	nau_pkg::nau_fin_t    fin_c;

	always_comb begin
		xw   = WW'(ctl_s4.x);
		vw   = WW'(sig_s4);
		dw   = WW'(der_s4);
		xneg = ctl_s4.x[XW-1];
		hw   = K_HD;
		w    = '0;
		num_c = '0;
		fin_c.func = ctl_s4.func;
		fin_c.mode = ctl_s4.mode;
		fin_c.last = ctl_s4.last;
		fin_c.div  = 1'b0;
		fin_c.neg  = 1'b0;
		fin_c.base = 1'b0;
		if (ctl_s4.func == nau_pkg::FUNC_FWD) begin
			case (ctl_s4.mode)
				nau_pkg::MODE_SIGMOID: begin
					if (xneg) w = (K_ROM_ONE + K_HF) - vw;
					else w = vw + K_HF;
					num_c = NW'(w >>> nau_pkg::RND_SH);
				end
				nau_pkg::MODE_RELU: begin
					if (xneg) begin
						w = K_50 - xw;
						fin_c.div = 1'b1;
						fin_c.neg = 1'b1;
					end else if (xw > K_ONE) begin
						w = xw - (K_ONE - K_50);
						fin_c.div  = 1'b1;
						fin_c.base = 1'b1;
					end else begin
						w = xw;
					end
					num_c = NW'(w);
				end
				nau_pkg::MODE_TANH: begin
					// 2*sig(2|x|) - 1 folded into the rounding add
					if (xneg) begin
						w = (vw <<< 1) - (K_ROM_ONE - K_H50F);
						fin_c.div = 1'b1;
						fin_c.neg = 1'b1;
					end else begin
						w = (vw <<< 1) - (K_ROM_ONE - K_HF);
					end
					num_c = NW'(w >>> nau_pkg::RND_SH);
				end
				default: begin
					num_c = '0;
				end
			endcase
		end else begin
			case (ctl_s4.mode)
				nau_pkg::MODE_SIGMOID: begin
					if (dw < 0) begin
						w = K_HD - dw;
						fin_c.neg = 1'b1;
					end else begin
						w = dw + K_HD;
					end
					num_c = NW'(w >>> nau_pkg::FRAC_BITS);
				end
				nau_pkg::MODE_RELU: begin
					if (xneg || xw > K_ONE) begin
						w = K_ONE + K_50;
						fin_c.div = 1'b1;
					end else begin
						w = K_ONE;
					end
					num_c = NW'(w);
				end
				nau_pkg::MODE_TANH: begin
					if (xneg) begin
						hw = K_H50D;
						fin_c.div = 1'b1;
					end
					if (dw < 0) begin
						w = hw - dw;
						fin_c.neg = 1'b1;
					end else begin
						w = dw + hw;
					end
					num_c = NW'(w >>> nau_pkg::FRAC_BITS);
				end
				default: begin
					num_c = '0;
				end
			endcase
		end
	end

	logic              vld_s5, vld_s6, vld_s7;
	nau_pkg::nau_fin_t fin_s5, fin_s6, fin_s7;
	logic [NW-1:0]     num_s5, num_s6, num_s7;
	logic [nau_pkg::Q_W-1:0] quo_s7;

	always_ff @(posedge clk) begin
		fin_s5 <= fin_c;
		num_s5 <= num_c;
		fin_s6 <= fin_s5;
		num_s6 <= num_s5;
		fin_s7 <= fin_s6;
		num_s7 <= num_s6;
	end

	// ---------------- stages 6-7: divide by 100 ----------------
	nau_div100 u_div (
		.clk (clk),
		.num (num_s5),
		.quo (quo_s7)
	);

	// ---------------- stage 8: sign and saturation ----------------
	logic [NW:0]          mag8_c;
	logic signed [XW-1:0] res_c;

	always_comb begin
		if (fin_s7.div) mag8_c = (NW+1)'(quo_s7);
		else mag8_c = (NW+1)'(num_s7);
		if (fin_s7.base) mag8_c = mag8_c + (NW+1)'(nau_pkg::ONE_Q);
		if (fin_s7.neg) begin
			if (mag8_c > K_SAT_NEG) res_c = {1'b1, {(XW-1){1'b0}}};
			else res_c = XW'((NW+1)'(0) - mag8_c);
		end else begin
			if (mag8_c > K_SAT_POS) res_c = XW'(K_SAT_POS);
			else res_c = XW'(mag8_c);
		end
	end

	logic              vld_s8;
	nau_pkg::nau_rsp_t rsp_s8;

	always_ff @(posedge clk) begin
		rsp_s8.result   <= res_c;
		rsp_s8.last_out <= fin_s7.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	assign done = vld_s8;
	assign rsp  = rsp_s8;

	// ---------------- checks ----------------
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> ##8 done)
		else $error("request did not complete after eight cycles");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.last_out == $past(req.is_last, 8))
		else $error("last flag out of step with its request");

	a_sig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && fin_s7.func == nau_pkg::FUNC_FWD && fin_s7.mode == nau_pkg::MODE_SIGMOID)
		|=> (rsp.result >= 0 && rsp.result <= nau_pkg::ONE_Q))
		else $error("sigmoid result outside zero to one");

	a_relu_der: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s7 && fin_s7.func == nau_pkg::FUNC_DER && fin_s7.mode == nau_pkg::MODE_RELU)
		|=> (rsp.result == nau_pkg::ONE_Q || rsp.result == nau_pkg::RELU_DER_LOW))
		else $error("ReLU derivative is neither slope");

endmodule

// ----- design/nau_regs.sv -----
module nau_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [nau_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output nau_pkg::mode_t                   mode
);

	nau_pkg::mode_t                      mode_q;
	logic [nau_pkg::REG_IDX_W-1:0]       reg_idx;

	assign reg_idx = paddr[nau_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;
	assign mode    = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= nau_pkg::MODE_RELU;
		end else if (psel && penable && pwrite && reg_idx == nau_pkg::REG_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	always_comb begin
		if (reg_idx == nau_pkg::REG_MODE) prdata = {30'd0, mode_q};
		else prdata = '0;
	end

endmodule

// ----- design/nau_sigmoid.sv -----
module nau_sigmoid (
	input  logic                          clk,
	input  nau_pkg::nau_lut_t             lut,
	output logic [nau_pkg::ROM_W-1:0]     sig
);

	localparam int RW = nau_pkg::ROM_W;
	localparam int PW = nau_pkg::POS_SH;

	logic [RW-1:0] rom [nau_pkg::TABLE_ENTRIES+1];

	for (genvar k = 0; k <= nau_pkg::TABLE_ENTRIES; k++) begin : g_rom
		assign rom[k] = nau_pkg::rom_entry(k);
	end

	logic [nau_pkg::IDX_W-1:0] idx_nxt;
	logic [RW-1:0]             lo_c;
	logic [RW-1:0]             hi_c;
	logic [RW+PW-1:0]          step_c;

	logic [RW-1:0] lo_s2;
	logic [RW-1:0] diff_s2;
	logic [PW-1:0] frac_s2;
	logic          dn_s2;
	logic          oor_s2;

	logic [RW-1:0] lo_s3;
	logic [RW-1:0] step_s3;
	logic          dn_s3;
	logic          oor_s3;

	logic [RW-1:0] sig_s4;

	assign idx_nxt = lut.idx + 1'b1;
	assign lo_c    = rom[lut.idx];
	assign hi_c    = rom[idx_nxt];
	assign step_c  = diff_s2 * frac_s2;

	always_ff @(posedge clk) begin
		lo_s2   <= lo_c;
		dn_s2   <= hi_c < lo_c;
		diff_s2 <= (hi_c < lo_c) ? lo_c - hi_c : hi_c - lo_c;
		frac_s2 <= lut.frac;
		oor_s2  <= lut.oor;

		lo_s3   <= lo_s2;
		step_s3 <= RW'(step_c >> PW);
		dn_s3   <= dn_s2;
		oor_s3  <= oor_s2;

		// beyond the table the curve is taken as exactly one
		if (oor_s3) sig_s4 <= RW'(nau_pkg::ROM_ONE);
		else if (dn_s3) sig_s4 <= lo_s3 - step_s3;
		else sig_s4 <= lo_s3 + step_s3;
	end

	assign sig = sig_s4;

endmodule

// ----- design/nau_div100.sv -----
module nau_div100 (
	input  logic                          clk,
	input  logic [nau_pkg::NUM_W-1:0]     num,
	output logic [nau_pkg::Q_W-1:0]       quo
);

	localparam int NW = nau_pkg::NUM_W;
	localparam int QW = nau_pkg::Q_W;

	logic [NW+nau_pkg::RECIP_W-1:0] prod_c;
	logic [NW-1:0]                  rem_c;

	logic [NW-1:0] num_s6;
	logic [QW-1:0] q0_s6;
	logic [QW-1:0] quo_s7;

	// reciprocal estimate is low by at most one
	assign prod_c = num * nau_pkg::RECIP_W'(nau_pkg::RECIP);
	assign rem_c  = num_s6 - NW'(q0_s6) * NW'(nau_pkg::SCALE_DIV);

	always_ff @(posedge clk) begin
		num_s6 <= num;
		q0_s6  <= QW'(prod_c >> NW);
		if (rem_c >= NW'(nau_pkg::SCALE_DIV)) quo_s7 <= q0_s6 + 1'b1;
		else quo_s7 <= q0_s6;
	end

	assign quo = quo_s7;

endmodule
